>>> hw/rtl/kca_pkg.sv
// Package for the keypad click and autorepeat block: key table, widths, register map.
package kca_pkg;

  localparam int TABLE_LEN = 16;
  localparam int KEY_W     = 5;
  localparam int DELAY_W   = 16;
  localparam int WORD_W    = 32;
  localparam int ADDR_W    = 3;

  // Register map, selected by address bit 2
  localparam logic REG_FIRST_DELAY  = 1'b0;
  localparam logic REG_REPEAT_DELAY = 1'b1;

  localparam logic [DELAY_W-1:0] FIRST_DELAY_RST  = 16'd500;
  localparam logic [DELAY_W-1:0] REPEAT_DELAY_RST = 16'd175;

  localparam logic [TABLE_LEN-1:0] KEY_GROUP = 16'b1111_1111_0001_1111;

  localparam logic [WORD_W-1:0] KEY_MASK [TABLE_LEN] = '{
    32'h0010_0000, 32'h0008_0000, 32'h0001_0000, 32'h0004_0000,
    32'h0002_0000, 32'hC000_0000, 32'h8000_0000, 32'h4000_0000,
    32'h0000_0010, 32'h0000_0008, 32'h0800_0000, 32'h0400_0000,
    32'h0000_1000, 32'h0100_0000, 32'h0200_0000, 32'h1000_0000
  };

endpackage

>>> hw/rtl/keypad_click_autorepeat.sv
// Keypad scan decoder: pressed, clicked and typematic autorepeat key per scan.
// An accepted scan is decoded combinationally and its result registered in the output register.
// Throughput: one scan per cycle if not stalled; the key decode, priority encode and the
// single elapsed-time subtract and compare sit between the input port and the output register.
// in_stall rises only while a result waits in the output register under out_stall.
// Synchronous reset: nothing pressed, no held key, delays 500 ms and 175 ms.
module keypad_click_autorepeat
  import kca_pkg::*;
#(
  parameter int NUM_KEYS  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [WORD_W-1:0]   keys_group_zero,
  input  logic [WORD_W-1:0]   keys_group_one,
  input  logic [WORD_W-1:0]   time_ms,
  input  logic                clear_held,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KEY_W-1:0]    repeat_key,
  output logic [KEY_W-1:0]    clicked_key,
  output logic [KEY_W-1:0]    pressed_key,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [WORD_W-1:0]   pwdata,
  output logic [WORD_W-1:0]   prdata,
  output logic                pready
);

  localparam int KEYS_IN_USE = (NUM_KEYS < TABLE_LEN) ? NUM_KEYS : TABLE_LEN;
  localparam int NUM_CODES   = 2 ** KEY_W;

  logic [DELAY_W-1:0]   first_delay;
  logic [DELAY_W-1:0]   repeat_delay;
  logic [WORD_W-1:0]    prev_group_zero;
  logic [WORD_W-1:0]    prev_group_one;
  logic [KEY_W-1:0]     held_key;
  logic [TIME_BITS-1:0] last_emit_time;
  logic                 repeating;

  logic [KEY_W-1:0]     held_key_next;
  logic [TIME_BITS-1:0] last_emit_time_next;
  logic                 repeating_next;
  logic [KEY_W-1:0]     emit_key;
  logic [KEY_W-1:0]     pressed_code;
  logic [KEY_W-1:0]     clicked_code;

  logic                 in_accept;
  logic                 cfg_write;
  logic [NUM_CODES-1:0] down_code;
  logic [NUM_CODES-1:0] prev_code;
  logic [KEY_W-1:0]     held_eff;
  logic [63:0]          time_wide;
  logic [TIME_BITS-1:0] now;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] limit;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_REPEAT_DELAY) ? WORD_W'(repeat_delay)
                                                    : WORD_W'(first_delay);

  assign in_stall  = out_valid && out_stall;
  assign in_accept = in_valid && !in_stall;

  assign time_wide = {32'd0, time_ms};
  assign now       = time_wide[TIME_BITS-1:0];

  // Bit k+1 flags key k down; code 0 and codes past the table read as up
  always_comb begin
    down_code = '0;
    prev_code = '0;
    for (int i = 0; i < KEYS_IN_USE; i++) begin
      down_code[i+1] = ((KEY_GROUP[i] ? keys_group_one : keys_group_zero) & KEY_MASK[i]) == '0;
      prev_code[i+1] = ((KEY_GROUP[i] ? prev_group_one : prev_group_zero) & KEY_MASK[i]) == '0;
    end
  end

  // Lowest table index wins
  always_comb begin
    pressed_code = '0;
    clicked_code = '0;
    for (int i = KEYS_IN_USE; i >= 1; i--) begin
      if (down_code[i]) begin
        pressed_code = KEY_W'(i);
      end
      if (down_code[i] && !prev_code[i]) begin
        clicked_code = KEY_W'(i);
      end
    end
  end

  assign held_eff = clear_held ? '0 : held_key;
  assign elapsed  = now - last_emit_time;
  assign limit    = repeating ? TIME_BITS'(repeat_delay) : TIME_BITS'(first_delay);

  always_comb begin
    held_key_next       = held_key;
    last_emit_time_next = last_emit_time;
    repeating_next      = repeating;
    emit_key            = '0;
    priority if (clicked_code != '0) begin
      held_key_next       = clicked_code;
      repeating_next      = 1'b0;
      last_emit_time_next = now;
      emit_key            = clicked_code;
    end else if (down_code[held_eff]) begin
      held_key_next = held_eff;
      if (elapsed > limit) begin
        repeating_next      = 1'b1;
        last_emit_time_next = now;
        emit_key            = held_eff;
      end
    end else begin
      held_key_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_delay  <= FIRST_DELAY_RST;
      repeat_delay <= REPEAT_DELAY_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_REPEAT_DELAY) begin
        repeat_delay <= pwdata[DELAY_W-1:0];
      end else begin
        first_delay <= pwdata[DELAY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_group_zero <= '1;
      prev_group_one  <= '1;
      held_key        <= '0;
      last_emit_time  <= '0;
      repeating       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (in_accept) begin
        prev_group_zero <= keys_group_zero;
        prev_group_one  <= keys_group_one;
        held_key        <= held_key_next;
        last_emit_time  <= last_emit_time_next;
        repeating       <= repeating_next;
        out_valid       <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; hold while stalled
  always_ff @(posedge clk) begin
    if (in_accept) begin
      repeat_key  <= emit_key;
      clicked_key <= clicked_code;
      pressed_key <= pressed_code;
    end
  end

endmodule

>>> hw/rtl/kca_checker.sv
// Port-level checker for the keypad click and autorepeat block, with its bind.
module kca_checker
  import kca_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [KEY_W-1:0]  repeat_key,
  input logic [KEY_W-1:0]  clicked_key,
  input logic [KEY_W-1:0]  pressed_key
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(repeat_key) &&
      $stable(clicked_key) && $stable(pressed_key))
    else $error("stalled result changed");

  // Back-pressure only comes from a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // A click is always what gets emitted
  a_click_emits: assert property (@(posedge clk) disable iff (rst)
    out_valid && clicked_key != '0 |-> repeat_key == clicked_key)
    else $error("click not emitted");

  // Clicked key is pressed, so the first pressed key cannot come after it
  a_click_pressed: assert property (@(posedge clk) disable iff (rst)
    out_valid && clicked_key != '0 |-> pressed_key != '0 && pressed_key <= clicked_key)
    else $error("clicked key not consistent with pressed key");

  // Nothing is emitted when no key is down
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && pressed_key == '0 |-> repeat_key == '0 && clicked_key == '0)
    else $error("key emitted with nothing pressed");

endmodule

bind keypad_click_autorepeat kca_checker u_kca_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .repeat_key  (repeat_key),
  .clicked_key (clicked_key),
  .pressed_key (pressed_key)
);
